// File: hw/rtl/homography_inverse_warp_address_macros.svh
// Assertion macros shared by the checker of the warp address block.
// No dependencies.
`ifndef HOMOGRAPHY_INVERSE_WARP_ADDRESS_MACROS_SVH
`define HOMOGRAPHY_INVERSE_WARP_ADDRESS_MACROS_SVH
`define HIWA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HIWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/hiwa_pkg.sv
// Shared types and constants of the inverse warp address block.
// No dependencies.
`default_nettype none
package hiwa_pkg;
  localparam logic [2:0] RegOffX = 3'd0;
  localparam logic [2:0] RegOffY = 3'd1;
  localparam logic [2:0] RegRow0 = 3'd2;
  localparam logic [2:0] RegRow1 = 3'd3;
  localparam logic [2:0] RegRow2 = 3'd4;
  typedef struct packed {
    logic [11:0] off_x;
    logic [11:0] off_y;
    logic [62:0] row0;
    logic [62:0] row1;
    logic [62:0] row2;
  } cfg_t;
endpackage
`default_nettype wire

// File: hw/rtl/hiwa_regs.sv
// APB register file of the inverse warp address block.
// Depends on hiwa_pkg.
`default_nettype none
module hiwa_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output hiwa_pkg::cfg_t    cfg_o
);
  import hiwa_pkg::*;
  cfg_t cfg_q;
  logic [2:0] idx;
  assign idx = paddr[5:3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_x <= 12'd1600;
      cfg_q.off_y <= 12'd300;
      cfg_q.row0 <= 63'd65536;
      cfg_q.row1 <= 63'd65536 << 21;
      cfg_q.row2 <= 63'd65536 << 42;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (idx)
        RegOffX: cfg_q.off_x <= pwdata[11:0];
        RegOffY: cfg_q.off_y <= pwdata[11:0];
        RegRow0: cfg_q.row0 <= pwdata[62:0];
        RegRow1: cfg_q.row1 <= pwdata[62:0];
        RegRow2: cfg_q.row2 <= pwdata[62:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (idx)
      RegOffX: prdata = {52'd0, cfg_q.off_x};
      RegOffY: prdata = {52'd0, cfg_q.off_y};
      RegRow0: prdata = {1'b0, cfg_q.row0};
      RegRow1: prdata = {1'b0, cfg_q.row1};
      RegRow2: prdata = {1'b0, cfg_q.row2};
      default: prdata = '0;
    endcase
  end
  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// File: hw/rtl/hiwa_div.sv
// Pipelined restoring divider stage chain: unsigned NW-bit numerator by DW-bit divisor.
// One quotient bit per stage, payload rides alongside. Depends on nothing.
`default_nettype none
module hiwa_div #(
  parameter int unsigned NW = 80,
  parameter int unsigned DW = 64,
  parameter int unsigned PW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [PW-1:0]      pay_o
);
  logic             v_q [1:NW];
  logic [NW-1:0]    n_q [1:NW];
  logic [DW:0]      r_q [1:NW];
  logic [DW-1:0]    d_q [1:NW];
  logic [PW-1:0]    p_q [1:NW];
  for (genvar s = 0; s < NW; s++) begin : g_st
    logic          v_in;
    logic [NW-1:0] n_in;
    logic [DW:0]   r_in;
    logic [DW-1:0] d_in;
    logic [PW-1:0] p_in;
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign n_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign p_in = pay_i;
    end else begin : g_next
      assign v_in = v_q[s];
      assign n_in = n_q[s];
      assign r_in = r_q[s];
      assign d_in = d_q[s];
      assign p_in = p_q[s];
    end
    assign sh = {r_in, n_in[NW-1]};
    assign df = sh - {2'b00, d_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s+1] <= 1'b0;
      else if (en_i) v_q[s+1] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s+1] <= d_in;
        p_q[s+1] <= p_in;
        if (!df[DW+1]) begin
          r_q[s+1] <= df[DW:0];
          n_q[s+1] <= {n_in[NW-2:0], 1'b1};
        end else begin
          r_q[s+1] <= sh[DW:0];
          n_q[s+1] <= {n_in[NW-2:0], 1'b0};
        end
      end
    end
  end
  assign valid_o = v_q[NW];
  assign quo_o = n_q[NW];
  assign pay_o = p_q[NW];
endmodule
`default_nettype wire

// File: hw/rtl/hiwa_map.sv
// Front pipeline: offsets, normalization, matrix products, numerators.
// Depends on hiwa_pkg.
`default_nettype none
module hiwa_map #(
  parameter int unsigned SRC_WIDTH = 1600,
  parameter int unsigned SRC_HEIGHT = 1200
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [11:0]         x_i,
  input  wire logic [11:0]         y_i,
  input  hiwa_pkg::cfg_t           cfg_i,
  output logic                     valid_o,
  output logic [23:0]              pos_o,
  output logic signed [79:0]       nx_o,
  output logic signed [79:0]       ny_o,
  output logic signed [63:0]       d_o
);
  import hiwa_pkg::*;
  localparam logic signed [27:0] Wd = 28'(SRC_WIDTH);
  localparam logic signed [27:0] Hd = 28'(SRC_HEIGHT);
  localparam logic signed [27:0] Cc = 28'(SRC_WIDTH * SRC_HEIGHT);
  // stage 1: a, b
  logic v1_q, v2_q, v3_q, v4_q;
  logic [23:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [27:0] a_q, b_q;
  logic signed [13:0] dx, dy;
  assign dx = $signed({2'b0, x_i}) - $signed({2'b0, cfg_i.off_x});
  assign dy = $signed({2'b0, y_i}) - $signed({2'b0, cfg_i.off_y});
  // stage 2: nine products
  logic signed [48:0] pr_q [3][3];
  // stage 3: g rows
  logic signed [52:0] g_q [3];
  function automatic logic signed [20:0] cf(input logic [62:0] r, input int k);
    cf = $signed(r[21*k +: 21]);
  endfunction
  logic [62:0] rows [3];
  assign rows[0] = cfg_i.row0;
  assign rows[1] = cfg_i.row1;
  assign rows[2] = cfg_i.row2;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= {y_i, x_i}; p2_q <= p1_q; p3_q <= p2_q; p4_q <= p3_q;
      a_q <= (28'(dx) * 28'sd2 - Wd) * Hd;
      b_q <= (28'(dy) * 28'sd2 - Hd) * Wd;
      for (int r = 0; r < 3; r++) begin
        pr_q[r][0] <= 49'(cf(rows[r], 0)) * 49'(a_q);
        pr_q[r][1] <= 49'(cf(rows[r], 1)) * 49'(b_q);
        pr_q[r][2] <= 49'(cf(rows[r], 2)) * 49'(Cc);
      end
      for (int r = 0; r < 3; r++)
        g_q[r] <= 53'(pr_q[r][0]) + 53'(pr_q[r][1]) + 53'(pr_q[r][2]);
      nx_o <= (80'(g_q[0]) + 80'(g_q[2])) * 80'(Wd);
      ny_o <= (80'(g_q[1]) + 80'(g_q[2])) * 80'(Hd);
      d_o <= 64'(g_q[2]) * 64'sd2;
    end
  end
  assign valid_o = v4_q;
  assign pos_o = p4_q;
endmodule
`default_nettype wire

// File: hw/rtl/homography_inverse_warp_address.sv
// Inverse perspective warp address generator.
// Input channel: out_x_i/out_y_i with in_valid_i, in_stall_o. One transaction
// per clock is accepted while the output side is not stalled.
// Output channel: dest, src and inside_res with out_valid_o, out_stall_i.
// Pipeline: 4 front stages, 80 divider stages (one quotient bit each) and one
// output stage. Throughput: one transaction per cycle while not stalled.
// The whole pipeline advances together; when the receiver stalls and the
// output register is full, every stage holds and in_stall_o rises, so no
// transaction is lost or repeated.
// Reset clears all valid bits and loads the identity matrix, offsets
// 1600 and 300. Registers are written through the APB port at 8*index
// and should only be changed while the pipeline is empty.
// Depends on hiwa_pkg, hiwa_regs, hiwa_map, hiwa_div.
`default_nettype none
module homography_inverse_warp_address #(
  parameter int unsigned SRC_WIDTH = 1600,
  parameter int unsigned SRC_HEIGHT = 1200
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [11:0] out_x_i,
  input  wire logic [11:0] out_y_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      dest_x_o,
  output logic [11:0]      dest_y_o,
  output logic signed [15:0] src_x_o,
  output logic signed [15:0] src_y_o,
  output logic             inside_res_o
);
  import hiwa_pkg::*;
  cfg_t cfg;
  logic en;
  assign pready = 1'b1;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  hiwa_regs u_regs (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
                    .prdata, .cfg_o(cfg));
  logic mv;
  logic [23:0] mpos;
  logic signed [79:0] nx, ny;
  logic signed [63:0] dd;
  hiwa_map #(.SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT)) u_map (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .x_i(out_x_i), .y_i(out_y_i),
    .cfg_i(cfg), .valid_o(mv), .pos_o(mpos), .nx_o(nx), .ny_o(ny), .d_o(dd));
  // divide magnitudes, restore sign after
  logic sx_neg, sy_neg, dz;
  logic [79:0] anx, any_;
  logic [63:0] ad;
  assign sx_neg = nx[79] ^ dd[63];
  assign sy_neg = ny[79] ^ dd[63];
  assign dz = (dd == 64'sd0);
  assign anx = nx[79] ? 80'(-nx) : 80'(nx);
  assign any_ = ny[79] ? 80'(-ny) : 80'(ny);
  assign ad = dd[63] ? 64'(-dd) : 64'(dd);
  logic xv, yv;
  logic [79:0] qx, qy;
  logic [25:0] px;
  logic [0:0] py;
  hiwa_div #(.NW(80), .DW(64), .PW(26)) u_divx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(mv), .num_i(anx), .den_i(ad),
    .pay_i({mpos, sx_neg, dz}), .valid_o(xv), .quo_o(qx), .pay_o(px));
  hiwa_div #(.NW(80), .DW(64), .PW(1)) u_divy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(mv), .num_i(any_), .den_i(ad),
    .pay_i(sy_neg), .valid_o(yv), .quo_o(qy), .pay_o(py));
  logic signed [80:0] sqx, sqy;
  assign sqx = px[1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign sqy = py[0] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  function automatic logic [15:0] sat(input logic signed [80:0] q);
    if (q > 81'sd32767) sat = 16'h7fff;
    else if (q < -81'sd32768) sat = 16'h8000;
    else sat = q[15:0];
  endfunction
  logic v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en) v_q <= xv && yv;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dest_x_o <= px[13:2];
      dest_y_o <= px[25:14];
      if (px[0]) begin
        src_x_o <= '0; src_y_o <= '0; inside_res_o <= 1'b0;
      end else begin
        src_x_o <= sat(sqx);
        src_y_o <= sat(sqy);
        inside_res_o <= !sqx[80] && sqx < 81'(SRC_WIDTH) && !sqy[80] &&
                        sqy < 81'(SRC_HEIGHT);
      end
    end
  end
  assign out_valid_o = v_q;
endmodule
`default_nettype wire

// File: hw/rtl/homography_inverse_warp_address_checker.sv
// Port-level checker for the warp address block, bound to the top level.
// Depends on homography_inverse_warp_address_macros.svh.
`default_nettype none
`include "homography_inverse_warp_address_macros.svh"
module homography_inverse_warp_address_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic inside_res_o,
  input wire logic [15:0] src_x_o,
  input wire logic [11:0] dest_x_o
);
  `HIWA_ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `HIWA_ASSERT_IMPL(a_inside_pos, clk_i, rst_ni, out_valid_o && inside_res_o, !src_x_o[15])
  `HIWA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(dest_x_o))
endmodule
bind homography_inverse_warp_address homography_inverse_warp_address_checker u_chk (.*);
`default_nettype wire
